// ===== rtl/assert_macros.svh =====
// assertion macros used by the port checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge while reset is released
`define ADV_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every clock edge, reset included
`define ADV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/adv_pkg.sv =====
// types, constants and helpers of the adc divider voltage averager
`timescale 1ns / 1ps
package adv_pkg;

    // default window length
    localparam int unsigned ADV_SAMPLES = 16;

    // field widths
    localparam int SAMPLE_W   = 12;
    localparam int CHAN_W     = 4;
    localparam int VOLT_W     = 20;
    localparam int REF_W      = 13;
    localparam int CORR_W     = 12;
    localparam int THR_W      = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REF    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CORR   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THR    = 2'd3;

    localparam logic [REF_W-1:0] REF_RESET = 13'd3300;
    localparam logic [THR_W-1:0] THR_RESET = 10'd100;

    localparam logic [VOLT_W-1:0] VOLT_MAX = 20'hFFFFF;

    // datapath widths
    localparam int VAL_W   = 20;    // one sample value, signed
    localparam int SUM_W   = 29;    // window sum, signed
    localparam int POLY_W  = 52;    // cubic in q32, signed
    localparam int MUL_A_W = 41;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int K_W     = 17;    // ref_millivolts * 11
    localparam int NUM_W   = 38;    // dividend, signed
    localparam int QUOT_W  = NUM_W + 1;
    localparam int DEN_W   = 13;
    localparam int MEAN_MAG_W = 29; // window sum magnitude, ceil term included
    localparam int RECIP_W    = 30; // reciprocal of the window length
    localparam int FOLD_W     = 12; // 4095 = 2^12 - 1

    localparam logic [DEN_W-1:0] ADC_FULL_SCALE = 13'd4095;

    // cubic coefficients in q32; c0 carries the +0.5 rounding term
    localparam logic signed [POLY_W-1:0] COEF_C3  = -52'sd17045;
    localparam logic signed [POLY_W-1:0] COEF_C2  = 52'sd2317324;
    localparam logic signed [POLY_W-1:0] COEF_C1  = 52'sd1694190585;
    localparam logic signed [POLY_W-1:0] COEF_C0R = 52'sd930411199086;

    // horner step coefficient select
    localparam logic [1:0] COEF_SEL_C2 = 2'd0;
    localparam logic [1:0] COEF_SEL_C1 = 2'd1;
    localparam logic [1:0] COEF_SEL_C0 = 2'd2;

    // divider dividend select
    localparam logic DIV_SEL_MEAN = 1'b0;
    localparam logic DIV_SEL_VOLT = 1'b1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] adc_sample;
        logic [CHAN_W-1:0]   channel;
    } t_in;

    typedef struct packed {
        logic [VOLT_W-1:0] voltage_mv;
        logic [CHAN_W-1:0] result_channel;
    } t_out;

    typedef struct packed {
        logic       load_in;
        logic       chan_lat;
        logic       poly_step;
        logic [1:0] coef_sel;
        logic       acc_add;
        logic       sum_clr;
        logic       div_start;
        logic       div_sel;
        logic       mean_ld;
        logic       prod_ld;
        logic       out_ld;
    } t_cmd;

    typedef struct packed {
        logic filter_en;
        logic div_busy;
    } t_sts;

    function automatic logic signed [POLY_W-1:0] coef_of(input logic [1:0] sel);
        logic signed [POLY_W-1:0] c;
        case (sel)
            COEF_SEL_C2: c = COEF_C2;
            COEF_SEL_C1: c = COEF_C1;
            default:     c = COEF_C0R;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/adv_div.sv =====
// constant divider (window length or adc full scale) with floor rounding for signed dividends
`timescale 1ns / 1ps
module adv_div
    import adv_pkg::*;
#(
    parameter int unsigned SAMPLES = ADV_SAMPLES
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic                     i_sel,
    input  logic signed [NUM_W-1:0]  i_num,
    output logic                     o_busy,
    output logic signed [QUOT_W-1:0] o_quot
);

    // reciprocal of the window length, exact for magnitudes below 2^MEAN_MAG_W
    localparam int MEAN_SHIFT = MEAN_MAG_W + $clog2(SAMPLES);
    localparam logic [RECIP_W-1:0] MEAN_RECIP =
        RECIP_W'(((64'd1 << MEAN_SHIFT) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));
    localparam int PROD_W = MEAN_MAG_W + RECIP_W;

    logic             r_busy, n_busy;
    logic             r_sel, n_sel;
    logic             r_neg, n_neg;
    logic [NUM_W-1:0] r_rem, n_rem;
    logic [NUM_W-1:0] r_q, n_q;

    logic [NUM_W-1:0]  w_den;
    logic [NUM_W-1:0]  w_mag;
    logic [PROD_W-1:0] w_mean_prod;
    logic [NUM_W-1:0]  w_fold_hi;

    assign w_den = (i_sel == DIV_SEL_MEAN) ? NUM_W'(SAMPLES) : NUM_W'(ADC_FULL_SCALE);

    // floor for negatives: -ceil(|n| / d)
    assign w_mag = i_num[NUM_W-1]
                 ? NUM_W'(-i_num) + w_den - NUM_W'(1)
                 : NUM_W'(i_num);

    assign w_mean_prod = PROD_W'(r_rem[MEAN_MAG_W-1:0]) * PROD_W'(MEAN_RECIP);

    // each 4096 in the remainder is one more quotient step and 1 left over
    assign w_fold_hi = r_rem >> FOLD_W;

    always_comb begin
        n_busy = r_busy;
        n_sel  = r_sel;
        n_neg  = r_neg;
        n_rem  = r_rem;
        n_q    = r_q;
        if (i_start) begin
            n_busy = 1'b1;
            n_sel  = i_sel;
            n_neg  = i_num[NUM_W-1];
            n_rem  = w_mag;
            n_q    = '0;
        end else if (r_busy) begin
            if (r_sel == DIV_SEL_MEAN) begin
                n_q    = NUM_W'(w_mean_prod >> MEAN_SHIFT);
                n_busy = 1'b0;
            end else if (w_fold_hi != '0) begin
                n_q   = r_q + w_fold_hi;
                n_rem = NUM_W'(r_rem[FOLD_W-1:0]) + w_fold_hi;
            end else begin
                // remainder now below 4096; only 4095 itself holds one more
                if (r_rem[FOLD_W-1:0] == FOLD_W'(ADC_FULL_SCALE)) begin
                    n_q = r_q + NUM_W'(1);
                end
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_sel <= n_sel;
        r_neg <= n_neg;
        r_rem <= n_rem;
        r_q   <= n_q;
    end

    assign o_busy = r_busy;
    assign o_quot = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});

endmodule

// ===== rtl/adv_dp.sv =====
// datapath: config registers, shared multiplier, accumulator, divider, output stage
`timescale 1ns / 1ps
module adv_dp
    import adv_pkg::*;
#(
    parameter int unsigned SAMPLES = ADV_SAMPLES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in                   i_in,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    output t_out                  o_out
);

    logic                     r_filter;
    logic [REF_W-1:0]         r_ref;
    logic signed [CORR_W-1:0] r_corr;
    logic [THR_W-1:0]         r_thr;

    logic [SAMPLE_W-1:0]      r_x;
    logic                     r_filt;
    logic signed [POLY_W-1:0] r_poly;
    logic signed [SUM_W-1:0]  r_sum;
    logic [CHAN_W-1:0]        r_wchan;
    logic signed [VAL_W-1:0]  r_mean;
    logic signed [NUM_W-1:0]  r_prod;
    t_out                     r_out;

    logic [K_W-1:0]              w_k;
    logic signed [MUL_A_W-1:0]   w_mul_a;
    logic signed [MUL_B_W-1:0]   w_mul_b;
    logic signed [MUL_P_W-1:0]   w_prod;
    logic signed [VAL_W-1:0]     w_val;
    logic signed [NUM_W-1:0]     w_num;
    logic                        w_busy;
    logic signed [QUOT_W-1:0]    w_quot;
    logic signed [QUOT_W:0]      w_trim;
    logic [VOLT_W-1:0]           w_volt;

    // ref * 11 by shifts
    assign w_k = (K_W'(r_ref) << 3) + (K_W'(r_ref) << 1) + K_W'(r_ref);

    assign w_mul_a = i_cmd.poly_step ? r_poly[MUL_A_W-1:0] : MUL_A_W'(r_mean);
    assign w_mul_b = i_cmd.poly_step ? $signed(MUL_B_W'(r_x)) : $signed(MUL_B_W'(w_k));
    assign w_prod  = MUL_P_W'(w_mul_a) * MUL_P_W'(w_mul_b);

    // rounded cubic count is the integer part of the q32 value
    assign w_val = r_filt ? r_poly[POLY_W-1:32] : $signed(VAL_W'(r_x));

    assign w_num = (i_cmd.div_sel == DIV_SEL_MEAN) ? NUM_W'(r_sum) : r_prod;

    adv_div #(
        .SAMPLES (SAMPLES)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_sel   (i_cmd.div_sel),
        .i_num   (w_num),
        .o_busy  (w_busy),
        .o_quot  (w_quot)
    );

    // threshold, offset and clamp
    assign w_trim = (QUOT_W + 1)'(w_quot) + (QUOT_W + 1)'(r_corr);
    always_comb begin
        if (w_quot < $signed({1'b0, r_thr})) begin
            w_volt = '0;
        end else if (w_trim < 0) begin
            w_volt = '0;
        end else if (w_trim > $signed({1'b0, VOLT_MAX})) begin
            w_volt = VOLT_MAX;
        end else begin
            w_volt = w_trim[VOLT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter <= 1'b0;
            r_ref    <= REF_RESET;
            r_corr   <= '0;
            r_thr    <= THR_RESET;
            r_sum    <= '0;
            r_wchan  <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FILTER: r_filter <= i_cfg_data[0];
                    CFG_REF:    r_ref    <= i_cfg_data[REF_W-1:0];
                    CFG_CORR:   r_corr   <= $signed(i_cfg_data[CORR_W-1:0]);
                    CFG_THR:    r_thr    <= i_cfg_data[THR_W-1:0];
                    default:    ;
                endcase
            end
            if (i_cmd.sum_clr) begin
                r_sum <= '0;
            end else if (i_cmd.acc_add) begin
                r_sum <= r_sum + SUM_W'(w_val);
            end
            if (i_cmd.load_in && i_cmd.chan_lat) begin
                r_wchan <= i_in.channel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_x    <= i_in.adc_sample;
            r_filt <= r_filter;
            r_poly <= COEF_C3;
        end else if (i_cmd.poly_step) begin
            r_poly <= w_prod[POLY_W-1:0] + coef_of(i_cmd.coef_sel);
        end
        if (i_cmd.mean_ld) begin
            r_mean <= w_quot[VAL_W-1:0];
        end
        if (i_cmd.prod_ld) begin
            r_prod <= w_prod[NUM_W-1:0];
        end
        if (i_cmd.out_ld) begin
            r_out.voltage_mv     <= w_volt;
            r_out.result_channel <= r_wchan;
        end
    end

    assign o_sts.filter_en = r_filter;
    assign o_sts.div_busy  = w_busy;
    assign o_out           = r_out;

endmodule

// ===== rtl/adv_ctrl.sv =====
// controller: sample sequencing, window count, divide steps and output handshake
`timescale 1ns / 1ps
module adv_ctrl
    import adv_pkg::*;
#(
    parameter int unsigned SAMPLES = ADV_SAMPLES
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam int CNT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MAC   = 4'd1;
    localparam logic [3:0] S_ACC   = 4'd2;
    localparam logic [3:0] S_DIV1  = 4'd3;
    localparam logic [3:0] S_WAIT1 = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_DIV2  = 4'd6;
    localparam logic [3:0] S_WAIT2 = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0]       r_state, n_state;
    logic [1:0]       r_step, n_step;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_ovalid, n_ovalid;
    logic             w_last;

    assign w_last = (r_cnt == CNT_W'(SAMPLES - 1));

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_cnt    = r_cnt;
        n_ovalid = (r_ovalid && !i_out_ready);
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in  = 1'b1;
                    o_cmd.chan_lat = (r_cnt == '0);
                    n_step         = COEF_SEL_C2;
                    n_state        = i_sts.filter_en ? S_MAC : S_ACC;
                end
            end
            S_MAC: begin
                o_cmd.poly_step = 1'b1;
                o_cmd.coef_sel  = r_step;
                if (r_step == COEF_SEL_C0) begin
                    n_state = S_ACC;
                end else begin
                    n_step = r_step + 2'd1;
                end
            end
            S_ACC: begin
                o_cmd.acc_add = 1'b1;
                if (w_last) begin
                    n_cnt   = '0;
                    n_state = S_DIV1;
                end else begin
                    n_cnt   = r_cnt + CNT_W'(1);
                    n_state = S_IDLE;
                end
            end
            S_DIV1: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_SEL_MEAN;
                o_cmd.sum_clr   = 1'b1;
                n_state         = S_WAIT1;
            end
            S_WAIT1: begin
                if (!i_sts.div_busy) begin
                    o_cmd.mean_ld = 1'b1;
                    n_state       = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.prod_ld = 1'b1;
                n_state       = S_DIV2;
            end
            S_DIV2: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_SEL_VOLT;
                n_state         = S_WAIT2;
            end
            S_WAIT2: begin
                if (!i_sts.div_busy) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.out_ld = 1'b1;
                    n_ovalid     = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;

endmodule

// ===== rtl/adc_divider_voltage_averager_core.sv =====
// top level of the adc divider voltage averager
//
// input channel: one adc sample and its channel number per transaction
// (i_in_valid / o_in_ready); the channel of a window's first sample tags it.
// output channel: one averaged reading per window of SAMPLES transactions
// (o_out_valid / i_out_ready), voltage in mV and the window's channel.
// config port: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 filter enable, 1 reference mV, 2 signed offset mV, 3 zero threshold mV);
// write only while the block is idle.
// per sample, with the filter off: accept, accumulate; with it on: accept, three
// horner steps on the shared multiplier, accumulate.
// window end: the mean is one reciprocal multiply, then the scaling multiply,
// then the divide by 4095 folds the remainder twelve bits per cycle (one to
// five steps), then the output load.
// the result sits in an output register, so the next window's samples are
// taken while the receiver stalls; only the next window end waits for it.
// reset (synchronous, active low) restores the register defaults, clears the
// window sum, count and channel, and drops o_out_valid.
`timescale 1ns / 1ps
module adc_divider_voltage_averager_core
    import adv_pkg::*;
#(
    parameter int unsigned SAMPLES = ADV_SAMPLES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // sample transactions
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in_data,
    // result transactions
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out_data,
    // config writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd w_cmd;   // controller to datapath
    t_sts w_sts;   // datapath to controller

    // sequencing, window counter and output valid
    adv_ctrl #(
        .SAMPLES (SAMPLES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // arithmetic, config registers and result register
    adv_dp #(
        .SAMPLES (SAMPLES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in_data),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_out      (o_out_data)
    );

endmodule

// ===== rtl/adv_chk.sv =====
// port checker for the averager top level, with its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"
module adv_chk
    import adv_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_in  i_in_data,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    // stalled result holds
    `ADV_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data), "result changed while stalled")

    // reset drops the result valid
    `ADV_ASSERT_ALWAYS(a_rst_clr, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

    // one sample at a time
    `ADV_ASSERT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && o_in_ready |=> !o_in_ready, "sample taken while busy")

    // a result appears only out of the window-end sequence
    `ADV_ASSERT(a_rise_busy, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(!o_in_ready), "result raised while idle")

endmodule

bind adc_divider_voltage_averager_core adv_chk u_adv_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ===== verif/adv_reading_checker.sv =====
// checker for the adc divider voltage averager: predicts and compares readings
`timescale 1ns / 1ps
module adv_reading_checker
    import adv_pkg::*;
#(
    parameter int unsigned WINDOW_LEN = ADV_SAMPLES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in                   i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out                  i_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_mismatches,
    output int                    o_pending,
    output int                    o_readings
);

    // cubic correction in q32
    localparam longint Q32_C0     = 64'sd928263715438;
    localparam longint Q32_C1     = 64'sd1694190585;
    localparam longint Q32_C2     = 64'sd2317324;
    localparam longint Q32_C3     = -64'sd17045;
    localparam longint ROUND_HALF = 64'sd2147483648;

    localparam longint DIVIDER_GAIN    = 11;
    localparam longint FULL_SCALE_CODE = 4095;
    localparam longint MV_CEILING      = 1048575;

    logic                     filter_on;
    logic [REF_W-1:0]         ref_mv;
    logic signed [CORR_W-1:0] offset_mv;
    logic [THR_W-1:0]         thr_mv;

    longint            window_sum;
    int unsigned       window_count;
    logic [CHAN_W-1:0] window_chan;

    t_out expected_readings[$];
    int   mismatches;
    int   readings;

    function automatic longint floor_quot(input longint n, input longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q -= 1;
        return q;
    endfunction

    function automatic longint corrected_count(input logic [SAMPLE_W-1:0] code);
        longint x;
        longint p;
        x = longint'(code);
        p = Q32_C0 + Q32_C1 * x + Q32_C2 * x * x + Q32_C3 * x * x * x;
        return (p + ROUND_HALF) >>> 32;
    endfunction

    function automatic logic [VOLT_W-1:0] window_reading_mv(input longint sum);
        longint mean;
        longint mv;
        mean = floor_quot(sum, longint'(WINDOW_LEN));
        mv = floor_quot(mean * longint'(ref_mv) * DIVIDER_GAIN, FULL_SCALE_CODE);
        if (mv < longint'(thr_mv)) begin
            mv = 0;
        end else begin
            mv += longint'(offset_mv);
            if (mv < 0)
                mv = 0;
            if (mv > MV_CEILING)
                mv = MV_CEILING;
        end
        return mv[VOLT_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            filter_on    = 1'b0;
            ref_mv       = REF_RESET;
            offset_mv    = '0;
            thr_mv       = THR_RESET;
            window_sum   = 0;
            window_count = 0;
            window_chan  = '0;
            mismatches   = 0;
            readings     = 0;
            expected_readings.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FILTER: filter_on = i_cfg_data[0];
                    CFG_REF:    ref_mv    = i_cfg_data[REF_W-1:0];
                    CFG_CORR:   offset_mv = i_cfg_data[CORR_W-1:0];
                    CFG_THR:    thr_mv    = i_cfg_data[THR_W-1:0];
                    default: ;
                endcase
            end

            if (i_out_valid && i_out_ready) begin
                readings++;
                if (expected_readings.size() == 0) begin
                    mismatches++;
                    $error("unexpected reading: voltage_mv %0d result_channel %0d",
                           i_out_data.voltage_mv, i_out_data.result_channel);
                end else begin
                    want = expected_readings.pop_front();
                    if (i_out_data.voltage_mv !== want.voltage_mv) begin
                        mismatches++;
                        $error("voltage_mv: expected %0d, actual %0d",
                               want.voltage_mv, i_out_data.voltage_mv);
                    end
                    if (i_out_data.result_channel !== want.result_channel) begin
                        mismatches++;
                        $error("result_channel: expected %0d, actual %0d",
                               want.result_channel, i_out_data.result_channel);
                    end
                end
            end

            if (i_in_valid && i_in_ready) begin
                if (window_count == 0)
                    window_chan = i_in_data.channel;
                if (filter_on)
                    window_sum += corrected_count(i_in_data.adc_sample);
                else
                    window_sum += longint'(i_in_data.adc_sample);
                window_count++;
                if (window_count == WINDOW_LEN) begin
                    want.voltage_mv     = window_reading_mv(window_sum);
                    want.result_channel = window_chan;
                    expected_readings.push_back(want);
                    window_sum   = 0;
                    window_count = 0;
                end
            end
        end
        o_mismatches <= mismatches;
        o_pending    <= expected_readings.size();
        o_readings   <= readings;
    end

endmodule

// ===== verif/tb_adc_divider_voltage_averager_core.sv =====
// testbench top: stimulus, config phases and verdict for the voltage averager
`timescale 1ns / 1ps
module tb_adc_divider_voltage_averager_core;
    import adv_pkg::*;

    // cycles to let the block finish a partial window's last sample or a window end
    localparam int SETTLE_CYCLES = 120;
    // receiver hold-off long enough to fill the output register and stall input
    localparam int LONG_HOLD     = 600;
    // cycles with no transaction at all before the run is called hung
    localparam int STALL_LIMIT   = 4000;
    localparam int FINAL_LIMIT   = 20000;
    localparam int RANDOM_PHASES = 14;

    // directed window: extremes and alternating bit patterns, filter switched on halfway
    localparam logic [SAMPLE_W-1:0] DIRECTED_CODES [16] = '{
        12'h000, 12'hFFF, 12'hAAA, 12'h555, 12'hFFF, 12'h000, 12'h001, 12'h800,
        12'h000, 12'hFFF, 12'hAAA, 12'h555, 12'd500, 12'h001, 12'hFFE, 12'd300
    };
    localparam logic [CHAN_W-1:0] DIRECTED_CHANS [16] = '{
        4'hF, 4'h0, 4'hA, 4'h5, 4'h0, 4'hF, 4'h5, 4'hA,
        4'h3, 4'hC, 4'h0, 4'hF, 4'h6, 4'h9, 4'h1, 4'hE
    };

    typedef struct {
        logic                     filter_on;
        logic [REF_W-1:0]         ref_mv;
        logic signed [CORR_W-1:0] offset_mv;
        logic [THR_W-1:0]         thr_mv;
    } t_adv_setting;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in                   i_in_data  = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out                  o_out_data;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = CFG_FILTER;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int mismatch_total;
    int readings_pending;
    int readings_checked;

    // idling switch shared by both sides; off for one whole phase
    bit gaps_on      = 1'b1;
    // raised by the sender, taken by the receiver process
    bit hold_request = 1'b0;

    int samples_sent    = 0;
    int settings_loaded = 0;
    int quiet_cycles    = 0;

    always #6 i_clk = ~i_clk;

    adc_divider_voltage_averager_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // predicts every reading and compares it on the output channel
    adv_reading_checker reading_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatch_total),
        .o_pending    (readings_pending),
        .o_readings   (readings_checked)
    );

    // one sample transaction; valid stays up until accepted
    // called in a time step where valid has not been assigned yet
    task automatic send_sample(input logic [SAMPLE_W-1:0] code, input logic [CHAN_W-1:0] chan);
        while (gaps_on && $urandom_range(0, 99) < 23) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{adc_sample: code, channel: chan};
        do @(posedge i_clk); while (!o_in_ready);
        samples_sent++;
    endtask

    // all readings out, then give the block time to finish any partial-window sample
    task automatic wait_idle();
        do @(posedge i_clk); while (readings_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // writes all four registers back to back; unused upper data bits of the filter and threshold writes get noise
    task automatic load_settings(input t_adv_setting s);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_FILTER;
        i_cfg_data <= {12'($urandom), s.filter_on};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_REF;
        i_cfg_data <= s.ref_mv;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_CORR;
        i_cfg_data <= {s.offset_mv[CORR_W-1], s.offset_mv};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_THR;
        i_cfg_data <= {3'($urandom), s.thr_mv};
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        settings_loaded++;
    endtask

    // receiver: random ready, plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= !(gaps_on && $urandom_range(0, 99) < 23);
            end
        end
    end

    // watchdog: any transaction or config write restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("adc_divider_voltage_averager_core test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // sender and run control
    initial begin
        t_adv_setting setting;
        int           n_items;
        int           scratch;
        int           waited;
        logic [SAMPLE_W-1:0] code;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed window at reset settings; filter turned on after eight samples,
        // so the window mixes raw and corrected values and spans a config write
        for (int i = 0; i < 16; i++) begin
            if (i == 8) begin
                i_in_valid <= 1'b0;
                wait_idle();
                setting = '{1'b1, 13'd3300, 12'sd0, 10'd0};
                load_settings(setting);
            end
            send_sample(DIRECTED_CODES[i], DIRECTED_CHANS[i]);
        end
        i_in_valid <= 1'b0;

        // random phases; lengths are mostly not whole windows, so register
        // writes also land between samples of one window
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_idle();
            case (phase)
                0: setting = '{1'b0, 13'd3300,  12'sd0,    10'd100};
                1: setting = '{1'b0, 13'd5000,  12'sd2000, 10'd0};
                2: setting = '{1'b0, 13'd0,    -12'sd2000, 10'd0};
                3: setting = '{1'b0, 13'd5000, -12'sd2000, 10'd1000};
                4: setting = '{1'b1, 13'd3300,  12'sd0,    10'd0};
                5: setting = '{1'b1, 13'd5000,  12'sd2000, 10'd1000};
                6: setting = '{1'b0, 13'd1,    -12'sd1,    10'd0};
                7: setting = '{1'b1, 13'd5000, -12'sd2000, 10'd0};
                default: begin
                    setting.filter_on = 1'($urandom_range(0, 1));
                    setting.ref_mv    = 13'($urandom_range(0, 5000));
                    scratch           = $urandom_range(0, 4000);
                    setting.offset_mv = 12'(scratch - 2000);
                    setting.thr_mv    = 10'($urandom_range(0, 1000));
                end
            endcase
            load_settings(setting);

            // phase 1 runs with no idling on either side
            gaps_on = (phase != 1);
            // phase 3 holds the receiver off while samples keep coming
            if (phase == 3)
                hold_request = 1'b1;

            n_items = $urandom_range(100, 160);
            for (int i = 0; i < n_items; i++) begin
                // corrected values stay positive only for low codes
                scratch = $urandom_range(0, 9);
                if (scratch == 0)
                    code = '0;
                else if (scratch == 1)
                    code = '1;
                else if (scratch < (setting.filter_on ? 8 : 4))
                    code = SAMPLE_W'($urandom_range(0, 600));
                else
                    code = SAMPLE_W'($urandom_range(0, 4095));
                send_sample(code, CHAN_W'($urandom_range(0, 15)));
            end
            i_in_valid <= 1'b0;
        end
        gaps_on = 1'b1;

        // drain: all readings in, then a margin for anything unexpected
        waited = 0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (readings_pending != 0 && waited < FINAL_LIMIT);

        if (readings_pending != 0) begin
            $display("adc_divider_voltage_averager_core test failed");
        end else begin
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            $display("%0d samples sent under %0d register settings, %0d readings checked",
                     samples_sent, settings_loaded, readings_checked);
            $display("raw and corrected windows, forced zero, offset clamp, long output hold-off");
            if (mismatch_total == 0)
                $display("adc_divider_voltage_averager_core test passed");
            else
                $display("adc_divider_voltage_averager_core test failed");
        end
        $finish;
    end

endmodule
